>>> rtl/core/ssfm_pkg.sv
`default_nettype none
package ssfm_pkg;

  // default sizes
  localparam int PatternMaxDef = 16;
  localparam int CountBitsDef  = 32;

  // pattern storage: two 64-bit registers, sixteen bytes
  localparam int PatBytes  = 16;
  localparam int PatIdxW   = $clog2(PatBytes);
  localparam int ApbDataW  = 64;
  localparam int ApbAddrW  = 5;
  localparam int LenRegW   = 5;

  typedef logic [PatBytes-1:0][7:0] pat_t;

  // register indexes, byte address = 8 * index
  typedef enum logic [1:0] {
    REG_PAT_LO  = 2'd0,
    REG_PAT_HI  = 2'd1,
    REG_PAT_LEN = 2'd2,
    REG_ICASE   = 2'd3
  } reg_idx_e;

  // configuration handed from the register file to the datapath
  typedef struct packed {
    pat_t               pattern;
    logic [LenRegW-1:0] len;
    logic               icase;
  } cfg_t;

  // ascii upper case to lower case when enabled
  function automatic logic [7:0] fold(input logic [7:0] b, input logic icase);
    logic [7:0] r;
    r = b;
    if (icase && (b >= 8'h41) && (b <= 8'h5a)) begin
      r = b + 8'h20;
    end
    return r;
  endfunction

  // pattern byte at a position, zero beyond the stored bytes
  function automatic logic [7:0] pat_byte(input pat_t p, input int idx);
    logic [7:0] r;
    r = 8'h00;
    if (idx < PatBytes) begin
      r = p[PatIdxW'(idx)];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/ssfm_regs.sv
`default_nettype none
module ssfm_regs (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [ssfm_pkg::ApbAddrW-1:0]   paddr,
  input  wire logic [ssfm_pkg::ApbDataW-1:0]   pwdata,
  output logic      [ssfm_pkg::ApbDataW-1:0]   prdata,
  output logic                                 pready,
  output ssfm_pkg::cfg_t                       cfg_o
);

  logic [63:0]                      pat_lo_q;
  logic [63:0]                      pat_hi_q;
  logic [ssfm_pkg::LenRegW-1:0]     len_q;
  logic                             icase_q;
  logic                             wr_en;
  ssfm_pkg::reg_idx_e               idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = ssfm_pkg::reg_idx_e'(paddr[4:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q <= '0;
      pat_hi_q <= '0;
      len_q    <= ssfm_pkg::LenRegW'(1);
      icase_q  <= 1'b0;
    end else if (wr_en) begin
      unique case (idx)
        ssfm_pkg::REG_PAT_LO:  pat_lo_q <= pwdata;
        ssfm_pkg::REG_PAT_HI:  pat_hi_q <= pwdata;
        ssfm_pkg::REG_PAT_LEN: len_q    <= pwdata[ssfm_pkg::LenRegW-1:0];
        ssfm_pkg::REG_ICASE:   icase_q  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      ssfm_pkg::REG_PAT_LO:  prdata = pat_lo_q;
      ssfm_pkg::REG_PAT_HI:  prdata = pat_hi_q;
      ssfm_pkg::REG_PAT_LEN: prdata = 64'(len_q);
      ssfm_pkg::REG_ICASE:   prdata = 64'(icase_q);
      default:               prdata = '0;
    endcase
  end

  assign cfg_o.pattern = ssfm_pkg::pat_t'({pat_hi_q, pat_lo_q});
  assign cfg_o.len     = len_q;
  assign cfg_o.icase   = icase_q;

endmodule
`default_nettype wire

>>> rtl/core/ssfm_match.sv
`default_nettype none
module ssfm_match #(
  parameter int PATTERN_MAX = ssfm_pkg::PatternMaxDef,
  localparam int LenW       = $clog2(PATTERN_MAX + 1)
) (
  input  wire logic [PATTERN_MAX-1:0][7:0] win_i,
  input  ssfm_pkg::pat_t                   pattern_i,
  input  wire logic [LenW-1:0]             len_i,
  input  wire logic                        icase_i,
  output logic                             hit_o
);

  // window entry k (newest at 0) lines up with pattern byte len-1-k
  always_comb begin
    int         pos;
    logic [7:0] pb;
    hit_o = 1'b1;
    pos   = 0;
    pb    = 8'h00;
    for (int k = 0; k < PATTERN_MAX; k++) begin
      if (k < int'(len_i)) begin
        pos = int'(len_i) - 1 - k;
        pb  = ssfm_pkg::pat_byte(pattern_i, pos);
        if (ssfm_pkg::fold(win_i[k], icase_i) != ssfm_pkg::fold(pb, icase_i)) begin
          hit_o = 1'b0;
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/substring_search_first_match.sv
`default_nettype none
// channel | signals                                   | direction
// --------+-------------------------------------------+----------
// text in | in_valid_i/in_ready_o, text_byte_i,       | in
//         | last_byte_i                               |
// result  | out_valid_o/out_ready_i, found_o,         | out
//         | match_offset_o                            |
// config  | apb: psel, penable, pwrite, paddr, pwdata,| in/out
//         | prdata, pready                            |
//
// one item per cycle sustained while no result is held back; an item waits in the input register
// and its result (if any) is registered in the result register when the item moves on
// the window compare is one parallel level of byte comparators between the
// input register and the result register
// reset clears window, byte count, match flag, pipeline valids and configuration registers
// a result held by out_ready_i low stalls the item in the input register, result or not
module substring_search_first_match #(
  parameter int PATTERN_MAX = ssfm_pkg::PatternMaxDef,
  parameter int COUNT_BITS  = ssfm_pkg::CountBitsDef
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // text item channel
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [7:0]                      text_byte_i,
  input  wire logic                            last_byte_i,
  // result item channel
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic                                 found_o,
  output logic      [31:0]                     match_offset_o,
  // configuration
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [ssfm_pkg::ApbAddrW-1:0]   paddr,
  input  wire logic [ssfm_pkg::ApbDataW-1:0]   pwdata,
  output logic      [ssfm_pkg::ApbDataW-1:0]   prdata,
  output logic                                 pready
);

  localparam int LenW = $clog2(PATTERN_MAX + 1);

  ssfm_pkg::cfg_t cfg;

  ssfm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // input register
  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       last_q;

  // search state
  logic [PATTERN_MAX-1:0][7:0] win_q, win_d, win_sh;
  logic [COUNT_BITS-1:0]       cnt_q, cnt_d, cnt_inc;
  logic                        rep_q, rep_d;

  // result register
  logic        out_valid_q, out_valid_d;
  logic        found_q, found_d;
  logic [31:0] off_q, off_d;

  logic            fire;
  logic            hit;
  logic            enough;
  logic [LenW-1:0] act_len;
  logic [COUNT_BITS-1:0] start;
  logic [63:0]     start_w, cnt_w;

  // a new item moves into the result stage once the result slot is free
  assign fire       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= text_byte_i;
      last_q <= last_byte_i;
    end
  end

  // pattern length clamped to 1 .. PATTERN_MAX
  always_comb begin
    if (cfg.len == '0) begin
      act_len = LenW'(1);
    end else if (int'(cfg.len) > PATTERN_MAX) begin
      act_len = LenW'(PATTERN_MAX);
    end else begin
      act_len = LenW'(cfg.len);
    end
  end

  // window after this byte, newest at entry 0
  always_comb begin
    win_sh[0] = byte_q;
    for (int k = 1; k < PATTERN_MAX; k++) begin
      win_sh[k] = win_q[k-1];
    end
  end

  // saturating byte count
  assign cnt_inc = (&cnt_q) ? cnt_q : cnt_q + COUNT_BITS'(1);
  assign enough  = (cnt_inc >= COUNT_BITS'(act_len));
  assign start   = cnt_inc - COUNT_BITS'(act_len);
  assign start_w = 64'(start);
  assign cnt_w   = 64'(cnt_inc);

  ssfm_match #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_match (
    .win_i     (win_sh),
    .pattern_i (cfg.pattern),
    .len_i     (act_len),
    .icase_i   (cfg.icase),
    .hit_o     (hit)
  );

  always_comb begin
    win_d       = win_q;
    cnt_d       = cnt_q;
    rep_d       = rep_q;
    out_valid_d = out_valid_q && !out_ready_i;
    found_d     = found_q;
    off_d       = off_q;
    if (fire) begin
      if (!rep_q) begin
        win_d = win_sh;
        cnt_d = cnt_inc;
        if (hit && enough) begin
          // first match of this text
          out_valid_d = 1'b1;
          found_d     = 1'b1;
          off_d       = (start_w > 64'hffff_ffff) ? 32'hffff_ffff : start_w[31:0];
          rep_d       = 1'b1;
        end else if (last_q) begin
          // text ended without a match: report its length
          out_valid_d = 1'b1;
          found_d     = 1'b0;
          off_d       = (cnt_w > 64'hffff_ffff) ? 32'hffff_ffff : cnt_w[31:0];
        end
      end
      if (last_q) begin
        win_d = '0;
        cnt_d = '0;
        rep_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q       <= '0;
      cnt_q       <= '0;
      rep_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      win_q       <= win_d;
      cnt_q       <= cnt_d;
      rep_q       <= rep_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    found_q <= found_d;
    off_q   <= off_d;
  end

  assign out_valid_o    = out_valid_q;
  assign found_o        = found_q;
  assign match_offset_o = off_q;

endmodule
`default_nettype wire

>>> tb/sv/substring_search_first_match_tb.sv
`default_nettype none
module substring_search_first_match_tb;

  // what the directed plan does per row: send a text item or write a register
  typedef enum logic {
    ROW_TEXT,
    ROW_WRITE
  } row_kind_e;

  typedef struct {
    row_kind_e           kind;
    ssfm_pkg::reg_idx_e  reg_sel;
    logic [63:0]         value;
    logic [7:0]          text;
    bit                  is_last;
    bit                  typed;
    bit                  exp_found;
    logic [31:0]         exp_offset;
  } plan_row_t;

  // one search report as it leaves the block
  typedef struct packed {
    bit          found;
    logic [31:0] offset;
  } report_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_ready_o;
  logic [7:0]                    text_byte_i;
  logic                          last_byte_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  logic                          found_o;
  logic [31:0]                   match_offset_o;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [ssfm_pkg::ApbAddrW-1:0] paddr;
  logic [ssfm_pkg::ApbDataW-1:0] pwdata;
  logic [ssfm_pkg::ApbDataW-1:0] prdata;
  logic                          pready;

  // search state mirrored on the testbench side
  logic [7:0]  win_bytes [ssfm_pkg::PatBytes];
  logic [31:0] text_count;
  bit          match_done;
  logic [63:0] pat_lo_q;
  logic [63:0] pat_hi_q;
  logic [4:0]  pat_len_q;
  bit          icase_q;

  // reports the block still owes, oldest first
  report_t reports_due[$];

  // run bookkeeping
  int          errors;
  int unsigned items_sent;
  int unsigned texts_sent;
  int unsigned settings_done;
  int unsigned in_stall_cycles;
  int unsigned n_found;
  int unsigned n_missed;

  // idling knobs, changed per phase by the stimulus
  bit tx_idle_en;
  bit rx_idle_en;
  // asks the result side for one long hold-off
  bit stall_request;

  substring_search_first_match uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .text_byte_i   (text_byte_i),
    .last_byte_i   (last_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .found_o       (found_o),
    .match_offset_o(match_offset_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ascii upper case folds to lower case only in ignore-case mode
  function automatic logic [7:0] casefold(input logic [7:0] b);
    if (icase_q && b >= 8'h41 && b <= 8'h5a) begin
      return b + 8'h20;
    end
    return b;
  endfunction

  // pattern byte by position, zero past the two registers
  function automatic logic [7:0] pattern_char(input int unsigned idx);
    if (idx < 8) begin
      return pat_lo_q[8*idx +: 8];
    end
    if (idx < 16) begin
      return pat_hi_q[8*(idx-8) +: 8];
    end
    return 8'h00;
  endfunction

  // length register clamped into 1..PATTERN_MAX
  function automatic int unsigned active_len();
    if (pat_len_q == 5'd0) begin
      return 1;
    end
    if (pat_len_q > 5'(ssfm_pkg::PatternMaxDef)) begin
      return ssfm_pkg::PatternMaxDef;
    end
    return pat_len_q;
  endfunction

  // window, count and match flag back to their idle values
  function automatic void clear_text();
    foreach (win_bytes[k]) begin
      win_bytes[k] = 8'h00;
    end
    text_count = '0;
    match_done = 1'b0;
  endfunction

  // one text byte through the streaming window; returns 1 when a report is due
  function automatic bit search_step(input logic [7:0] b, input bit is_last,
                                     output report_t rep);
    int unsigned len;
    bit          hit;
    bit          due;
    due = 1'b0;
    rep = '0;
    if (!match_done) begin
      len = active_len();
      // newest byte at entry 0
      for (int k = ssfm_pkg::PatBytes - 1; k > 0; k--) begin
        win_bytes[k] = win_bytes[k-1];
      end
      win_bytes[0] = b;
      // saturating byte count
      if (text_count != '1) begin
        text_count = text_count + 1;
      end
      hit = (text_count >= len);
      // pattern byte len-1 lines up with the newest byte
      for (int k = 0; k < len; k++) begin
        if (casefold(win_bytes[k]) != casefold(pattern_char(len - 1 - k))) begin
          hit = 1'b0;
        end
      end
      if (hit) begin
        rep.found  = 1'b1;
        rep.offset = text_count - len;
        match_done = 1'b1;
        due        = 1'b1;
      end else if (is_last) begin
        // no match by the end of the text: report its length
        rep.found  = 1'b0;
        rep.offset = text_count;
        due        = 1'b1;
      end
    end
    // a finished text leaves nothing behind for the next one
    if (is_last) begin
      clear_text();
    end
    return due;
  endfunction

  // flips the case of a letter now and then, to exercise ignore-case mode
  function automatic logic [7:0] maybe_flip_case(input logic [7:0] b);
    if (((b >= 8'h41 && b <= 8'h5a) || (b >= 8'h61 && b <= 8'h7a)) &&
        $urandom_range(0, 2) == 0) begin
      return b ^ 8'h20;
    end
    return b;
  endfunction

  // small alphabet shared with the patterns, so partial matches are common
  function automatic logic [7:0] alpha_byte();
    return (8'h61 + 8'($urandom_range(0, 3))) ^ ($urandom_range(0, 1) ? 8'h20 : 8'h00);
  endfunction

  function automatic logic [7:0] pick_text_byte(input int unsigned eff);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return maybe_flip_case(pattern_char($urandom_range(0, eff - 1)));
      5, 6, 7:       return alpha_byte();
      default:       return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic plan_row_t text_row(input logic [7:0] b, input bit is_last);
    plan_row_t r;
    r         = '{kind: ROW_TEXT, reg_sel: ssfm_pkg::REG_PAT_LO, default: '0};
    r.text    = b;
    r.is_last = is_last;
    return r;
  endfunction

  // text item whose report is obvious from the setting
  function automatic plan_row_t known_row(input logic [7:0] b, input bit is_last,
                                          input bit f, input logic [31:0] off);
    plan_row_t r;
    r            = text_row(b, is_last);
    r.typed      = 1'b1;
    r.exp_found  = f;
    r.exp_offset = off;
    return r;
  endfunction

  function automatic plan_row_t write_row(input ssfm_pkg::reg_idx_e sel,
                                          input logic [63:0] v);
    plan_row_t r;
    r       = '{kind: ROW_WRITE, reg_sel: sel, default: '0};
    r.value = v;
    return r;
  endfunction

  // offers one text item, waits for the handshake, then predicts its report
  task automatic send_item(input logic [7:0] b, input bit is_last,
                           output bit due, output report_t rep);
    int unsigned idle_len;
    if (tx_idle_en && $urandom_range(0, 4) == 0) begin
      idle_len = $urandom_range(1, 3);
      in_valid_i <= 1'b0;
      repeat (idle_len) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    text_byte_i <= b;
    last_byte_i <= is_last;
    @(posedge clk_i);
    while (!in_ready_o) begin
      in_stall_cycles++;
      @(posedge clk_i);
    end
    due = search_step(b, is_last, rep);
    if (due) begin
      reports_due.push_back(rep);
    end
    items_sent++;
    if (is_last) begin
      texts_sent++;
    end
  endtask

  // idle the input and let every owed report drain, plus the pipeline depth
  task automatic settle();
    in_valid_i <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // apb write: setup cycle, access cycle, register taken when pready is high
  task automatic write_reg(input ssfm_pkg::reg_idx_e sel, input logic [63:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ssfm_pkg::ApbAddrW'({sel, 3'b000});
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (sel)
      ssfm_pkg::REG_PAT_LO:  pat_lo_q  = v;
      ssfm_pkg::REG_PAT_HI:  pat_hi_q  = v;
      ssfm_pkg::REG_PAT_LEN: pat_len_q = v[4:0];
      ssfm_pkg::REG_ICASE:   icase_q   = v[0];
      default:               ;
    endcase
    @(posedge clk_i);
  endtask

  // result side: checks each accepted report and throttles out_ready_i
  initial begin : result_sink
    int unsigned hold_left;
    report_t     want;
    hold_left   = 0;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        if (reports_due.size() == 0) begin
          errors++;
          $display("%0t: report with none owed: found %0b offset %0d",
                   $time, found_o, match_offset_o);
        end else begin
          want = reports_due.pop_front();
          if (found_o !== want.found) begin
            errors++;
            $display("%0t: found expected %0b actual %0b", $time, want.found, found_o);
          end
          if (match_offset_o !== want.offset) begin
            errors++;
            $display("%0t: match_offset expected %0d actual %0d",
                     $time, want.offset, match_offset_o);
          end
          if (want.found) begin
            n_found++;
          end else begin
            n_missed++;
          end
        end
      end
      // one long hold-off on request, otherwise short random bursts
      if (stall_request) begin
        hold_left     = 80;
        stall_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        hold_left = $urandom_range(0, 2);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // hard stop well past the slowest legal run
  initial begin : watchdog
    #(8 * 200000);
    $display("substring_search_first_match test failed");
    $finish;
  end

  initial begin : stimulus
    plan_row_t    plan[$];
    logic [7:0]   txt[$];
    logic [7:0]   leftover[$];
    logic [7:0]   b;
    logic [127:0] pat_gen;
    logic [4:0]   len_gen;
    bit           ic_gen;
    bit           due;
    bit           split;
    report_t      rep;
    int unsigned  n;
    int unsigned  cut;
    int unsigned  start;
    int unsigned  eff;
    int unsigned  ntexts;
    int           phase;

    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    text_byte_i     = 8'h00;
    last_byte_i     = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    errors          = 0;
    items_sent      = 0;
    texts_sent      = 0;
    settings_done   = 0;
    in_stall_cycles = 0;
    n_found         = 0;
    n_missed        = 0;
    tx_idle_en      = 1'b0;
    rx_idle_en      = 1'b0;
    stall_request   = 1'b0;
    // register values after reset
    pat_lo_q  = '0;
    pat_hi_q  = '0;
    pat_len_q = 5'd1;
    icase_q   = 1'b0;
    clear_text();

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset pattern is a single zero byte
    plan.push_back(known_row(8'h00, 1'b1, 1'b1, 32'd0));
    plan.push_back(known_row(8'hff, 1'b1, 1'b0, 32'd1));
    // length zero behaves as length one
    plan.push_back(write_row(ssfm_pkg::REG_PAT_LO, 64'hff));
    plan.push_back(write_row(ssfm_pkg::REG_PAT_LEN, 64'd0));
    plan.push_back(text_row(8'h41, 1'b0));
    plan.push_back(known_row(8'hff, 1'b1, 1'b1, 32'd1));
    // ignore case on both sides, then bytes after a match stay silent
    plan.push_back(write_row(ssfm_pkg::REG_PAT_LO, 64'h0000_0000_0063_6241));
    plan.push_back(write_row(ssfm_pkg::REG_PAT_LEN, 64'd3));
    plan.push_back(write_row(ssfm_pkg::REG_ICASE, 64'd1));
    plan.push_back(text_row("a", 1'b0));
    plan.push_back(text_row("B", 1'b0));
    plan.push_back(known_row("C", 1'b0, 1'b1, 32'd0));
    plan.push_back(text_row("a", 1'b1));
    // mode flipped mid-text: stored bytes fold with the new setting
    plan.push_back(write_row(ssfm_pkg::REG_ICASE, 64'd0));
    plan.push_back(text_row("A", 1'b0));
    plan.push_back(text_row("B", 1'b0));
    plan.push_back(write_row(ssfm_pkg::REG_ICASE, 64'd1));
    plan.push_back(known_row("C", 1'b1, 1'b1, 32'd0));
    // all-ones pattern, length clamped to sixteen
    plan.push_back(write_row(ssfm_pkg::REG_PAT_LO, '1));
    plan.push_back(write_row(ssfm_pkg::REG_PAT_HI, '1));
    plan.push_back(write_row(ssfm_pkg::REG_PAT_LEN, 64'd31));
    repeat (15) plan.push_back(text_row(8'hff, 1'b0));
    plan.push_back(known_row(8'hff, 1'b1, 1'b1, 32'd0));
    plan.push_back(write_row(ssfm_pkg::REG_PAT_LEN, 64'd17));
    plan.push_back(known_row(8'hff, 1'b1, 1'b0, 32'd1));

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        settle();
        write_reg(plan[i].reg_sel, plan[i].value);
      end else begin
        send_item(plan[i].text, plan[i].is_last, due, rep);
        if (plan[i].typed && (!due || rep.found != plan[i].exp_found ||
                              rep.offset != plan[i].exp_offset)) begin
          errors++;
          $display("%0t: row %0d expected found %0b offset %0d, predicted %0b %0d",
                   $time, i, plan[i].exp_found, plan[i].exp_offset, rep.found, rep.offset);
        end
      end
    end
    settings_done = 4;

    // random phases: new setting, then a batch of texts
    phase = 0;
    while (items_sent < 1050) begin
      settle();
      phase++;
      // idling only early on; the tail runs at full rate
      tx_idle_en = (items_sent < 900) && ($urandom_range(0, 3) != 0);
      rx_idle_en = (items_sent < 900) && ($urandom_range(0, 3) != 0);

      for (int j = 0; j < 16; j++) begin
        pat_gen[8*j +: 8] = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                         : alpha_byte();
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: len_gen = 5'($urandom_range(1, 4));
        6, 7:             len_gen = 5'($urandom_range(5, 16));
        8:                len_gen = 5'd16;
        default:          len_gen = 5'($urandom_range(0, 31));
      endcase
      ic_gen = $urandom_range(0, 1);
      // a few fixed corners among the random settings
      if (phase == 1) begin
        pat_gen = '0;
        len_gen = 5'd16;
      end else if (phase == 2) begin
        pat_gen = '1;
        len_gen = 5'd31;
        ic_gen  = 1'b1;
      end else if (phase == 3) begin
        len_gen = 5'd1;
        ic_gen  = 1'b0;
      end else if (phase % 5 == 0) begin
        len_gen = 5'd0;
      end
      write_reg(ssfm_pkg::REG_PAT_LO, pat_gen[63:0]);
      write_reg(ssfm_pkg::REG_PAT_HI, pat_gen[127:64]);
      write_reg(ssfm_pkg::REG_PAT_LEN, 64'(len_gen));
      write_reg(ssfm_pkg::REG_ICASE, 64'(ic_gen));
      settings_done++;
      eff = active_len();

      if (phase == 3) begin
        // one-byte texts, each with a report, against a long result hold-off
        stall_request = 1'b1;
        repeat (30) begin
          send_item(pick_text_byte(eff), 1'b1, due, rep);
        end
      end else begin
        // finish a text that the previous phase left open
        while (leftover.size() != 0) begin
          b = leftover.pop_front();
          send_item(b, leftover.size() == 0, due, rep);
        end
        ntexts = $urandom_range(3, 8);
        for (int t = 0; t < ntexts; t++) begin
          n = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 20);
          txt.delete();
          for (int i = 0; i < n; i++) begin
            txt.push_back(pick_text_byte(eff));
          end
          // mostly plant the whole pattern somewhere in the text
          if (n >= eff && $urandom_range(0, 9) < 6) begin
            start = $urandom_range(0, n - eff);
            for (int j = 0; j < eff; j++) begin
              txt[start + j] = maybe_flip_case(pattern_char(j));
            end
          end
          // sometimes the phase ends mid-text and the rest runs under the next setting
          split = (t == ntexts - 1) && (n > 1) && ($urandom_range(0, 3) == 0);
          cut   = split ? $urandom_range(1, n - 1) : n;
          for (int i = 0; i < cut; i++) begin
            send_item(txt[i], !split && (i == n - 1), due, rep);
          end
          for (int i = cut; i < n; i++) begin
            leftover.push_back(txt[i]);
          end
        end
      end
    end
    while (leftover.size() != 0) begin
      b = leftover.pop_front();
      send_item(b, leftover.size() == 0, due, rep);
    end

    // drain, then a few cycles for anything stray
    in_valid_i <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("ran %0d text bytes in %0d texts under %0d register settings",
             items_sent, texts_sent, settings_done);
    $display("reports: %0d matches, %0d without match; input held back %0d cycles",
             n_found, n_missed, in_stall_cycles);
    if (errors == 0) begin
      $display("substring_search_first_match test passed");
    end else begin
      $display("substring_search_first_match test failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> files.f
rtl/core/ssfm_pkg.sv
rtl/core/ssfm_regs.sv
rtl/core/ssfm_match.sv
rtl/core/substring_search_first_match.sv
tb/sv/substring_search_first_match_tb.sv
